>>> hdl/odm_pkg.sv
// Shared types, constants and register codes for the obstacle distance monitor.
// No dependencies; every other file in hdl/ refers to this package by scoped name.
`default_nettype none

package odm_pkg;

    // Sample window
    localparam int WINDOW      = 5;
    localparam int SAMPLE_W    = 10;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int SUM_W       = $clog2(WINDOW * SAMPLE_MAX + 1);

    // Divide by WINDOW as multiply by a rounded-up reciprocal; exact for every window sum
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam int TIME_W      = 32;
    localparam int MS_W        = 16;

    // Event codes
    localparam logic [1:0] KIND_UPDATE   = 2'd0;
    localparam logic [1:0] KIND_DETECTED = 2'd1;
    localparam logic [1:0] KIND_CLEARED  = 2'd2;

    // Register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_VALID_LIMIT     = 2'd0;
    localparam logic [1:0] REG_OBST_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_LOSS_TIMEOUT    = 2'd2;
    localparam logic [1:0] REG_REPORT_INTERVAL = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_VALID_LIMIT     = 10'd400;
    localparam logic [SAMPLE_W-1:0] RST_OBST_THRESHOLD  = 10'd25;
    localparam logic [MS_W-1:0]     RST_LOSS_TIMEOUT    = 16'd500;
    localparam logic [MS_W-1:0]     RST_REPORT_INTERVAL = 16'd50;

    // Output buffer
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int CREDIT_W   = FIFO_CNT_W + 1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } t_event;

    // Up to two words pushed per item
    typedef struct packed {
        logic [1:0] count;
        t_event     ev0;
        t_event     ev1;
    } t_push;

endpackage

`default_nettype wire

>>> hdl/odm_cell.sv
// One window cell: holds a sample and hands it to the next cell on a shift.
// Depends on odm_pkg.
`default_nettype none

module odm_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_shift,
    input  wire logic [odm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic      [odm_pkg::SAMPLE_W-1:0]  o_sample
);

    logic [odm_pkg::SAMPLE_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

>>> hdl/odm_window.sv
// Sample window: a chain of odm_cell instances plus a running sum of the chain.
// Depends on odm_pkg and odm_cell.
`default_nettype none

module odm_window (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_shift,
    input  wire logic [odm_pkg::SAMPLE_W-1:0]  i_sample,
    output logic      [odm_pkg::SUM_W-1:0]     o_sum
);

    logic [odm_pkg::SAMPLE_W-1:0] w_tap [odm_pkg::WINDOW+1];
    logic [odm_pkg::SUM_W-1:0]    r_sum;
    logic [odm_pkg::SUM_W-1:0]    n_sum;

    assign w_tap[0] = i_sample;

    for (genvar g = 0; g < odm_pkg::WINDOW; g++) begin : g_cell
        odm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (i_shift),
            .i_sample (w_tap[g]),
            .o_sample (w_tap[g+1])
        );
    end

    // Oldest sample drops off the end of the chain as the new one enters
    assign n_sum = r_sum + odm_pkg::SUM_W'(i_sample) - odm_pkg::SUM_W'(w_tap[odm_pkg::WINDOW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

>>> hdl/odm_event_fifo.sv
// Output buffer for event words: takes up to two words a cycle, gives one.
// Depends on odm_pkg.
`default_nettype none

module odm_event_fifo (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire odm_pkg::t_push                  i_push,
    input  wire logic                            i_pop,
    output odm_pkg::t_event                      o_head,
    output logic                                 o_valid,
    output logic      [odm_pkg::FIFO_CNT_W-1:0]  o_count
);

    odm_pkg::t_event                r_mem [odm_pkg::FIFO_DEPTH];
    logic [odm_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [odm_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [odm_pkg::FIFO_CNT_W-1:0] r_count;
    logic                           w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.ev0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + odm_pkg::FIFO_PTR_W'(1)] <= i_push.ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + odm_pkg::FIFO_PTR_W'(i_push.count);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + odm_pkg::FIFO_PTR_W'(1);
            end
            r_count <= r_count + odm_pkg::FIFO_CNT_W'(i_push.count)
                     - odm_pkg::FIFO_CNT_W'(w_pop);
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> hdl/obstacle_distance_monitor_top.sv
// Top level of the obstacle distance monitor: register port, window, divider, event logic.
// Depends on odm_pkg, odm_window (with odm_cell) and odm_event_fifo.
`default_nettype none

// Each accepted reading runs through three stages: the window chain and its running sum
// update in the accept cycle, the divide-by-window multiply fills the next, and the event
// decision then pushes zero, one or two words into an eight-word output buffer. A reading
// is taken in any cycle in which the output buffer can hold two words for it and for every
// item still in the pipeline. The output side gives one word per cycle while i_ready is
// high, so an item that raises two events gives two words, one with a single event gives
// one word and one with no event gives none.
module obstacle_distance_monitor_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [odm_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [odm_pkg::DATA_W-1:0]    pwdata,
    output logic      [odm_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    // reading input
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [odm_pkg::SAMPLE_W-1:0]  i_raw_distance,
    input  wire logic [odm_pkg::TIME_W-1:0]    i_now_ms,
    // event output
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [1:0]                    o_event_kind,
    output logic      [odm_pkg::SAMPLE_W-1:0]  o_event_value,
    output logic                               o_last_event
);

    // Configuration registers
    logic [odm_pkg::SAMPLE_W-1:0] r_valid_limit;
    logic [odm_pkg::SAMPLE_W-1:0] r_threshold;
    logic [odm_pkg::MS_W-1:0]     r_loss_timeout;
    logic [odm_pkg::MS_W-1:0]     r_report_interval;
    logic                         w_cfg_wr;
    logic [1:0]                   w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_limit     <= odm_pkg::RST_VALID_LIMIT;
            r_threshold       <= odm_pkg::RST_OBST_THRESHOLD;
            r_loss_timeout    <= odm_pkg::RST_LOSS_TIMEOUT;
            r_report_interval <= odm_pkg::RST_REPORT_INTERVAL;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                odm_pkg::REG_VALID_LIMIT:     r_valid_limit     <= pwdata[odm_pkg::SAMPLE_W-1:0];
                odm_pkg::REG_OBST_THRESHOLD:  r_threshold       <= pwdata[odm_pkg::SAMPLE_W-1:0];
                odm_pkg::REG_LOSS_TIMEOUT:    r_loss_timeout    <= pwdata[odm_pkg::MS_W-1:0];
                odm_pkg::REG_REPORT_INTERVAL: r_report_interval <= pwdata[odm_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            odm_pkg::REG_VALID_LIMIT:     prdata = odm_pkg::DATA_W'(r_valid_limit);
            odm_pkg::REG_OBST_THRESHOLD:  prdata = odm_pkg::DATA_W'(r_threshold);
            odm_pkg::REG_LOSS_TIMEOUT:    prdata = odm_pkg::DATA_W'(r_loss_timeout);
            odm_pkg::REG_REPORT_INTERVAL: prdata = odm_pkg::DATA_W'(r_report_interval);
            default:                      prdata = '0;
        endcase
    end

    // Stage A: accept, qualify the reading, shift it into the window if it qualifies
    logic                           w_accept;
    logic                           w_ok;
    logic [odm_pkg::SUM_W-1:0]      w_sum;
    logic [odm_pkg::FIFO_CNT_W-1:0] w_fifo_count;
    logic [odm_pkg::CREDIT_W-1:0]   w_need;

    // Reserve two words for this item and for each item in flight
    logic                           r_b_valid;
    logic                           r_c_valid;

    assign w_need = odm_pkg::CREDIT_W'(w_fifo_count)
                  + odm_pkg::CREDIT_W'({r_b_valid, 1'b0})
                  + odm_pkg::CREDIT_W'({r_c_valid, 1'b0})
                  + odm_pkg::CREDIT_W'(2);
    assign o_ready  = (w_need <= odm_pkg::CREDIT_W'(odm_pkg::FIFO_DEPTH));
    assign w_accept = i_valid && o_ready;
    assign w_ok     = (i_raw_distance != '0) && (i_raw_distance < r_valid_limit);

    odm_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_accept && w_ok),
        .i_sample (i_raw_distance),
        .o_sum    (w_sum)
    );

    // Stage B: average = sum / WINDOW
    logic                           r_b_ok;
    logic [odm_pkg::TIME_W-1:0]     r_b_now;
    logic [odm_pkg::PROD_W-1:0]     w_prod;

    assign w_prod = odm_pkg::PROD_W'(w_sum) * odm_pkg::PROD_W'(odm_pkg::RECIP);

    // Stage C: event decision
    logic                           r_c_ok;
    logic [odm_pkg::TIME_W-1:0]     r_c_now;
    logic [odm_pkg::SAMPLE_W-1:0]   r_c_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= w_accept;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_b_ok  <= w_ok;
            r_b_now <= i_now_ms;
        end
        r_c_ok  <= r_b_ok;
        r_c_now <= r_b_now;
        r_c_avg <= w_prod[odm_pkg::RECIP_SHIFT +: odm_pkg::SAMPLE_W];
    end

    logic                       r_flag;
    logic [odm_pkg::TIME_W-1:0] r_last_valid;
    logic [odm_pkg::TIME_W-1:0] r_last_report;
    logic [odm_pkg::TIME_W-1:0] w_since_valid;
    logic [odm_pkg::TIME_W-1:0] w_since_report;
    logic                       w_timeout;
    logic                       w_report;
    logic                       w_in_range;
    logic                       w_detect;
    logic                       w_clear;
    logic                       w_flag_ev;
    odm_pkg::t_event            w_update_ev;
    odm_pkg::t_event            w_flag_word;
    odm_pkg::t_push             w_push;

    assign w_since_valid  = r_c_now - r_last_valid;
    assign w_since_report = r_c_now - r_last_report;
    assign w_timeout      = w_since_valid > odm_pkg::TIME_W'(r_loss_timeout);
    assign w_report       = r_c_ok && (w_since_report > odm_pkg::TIME_W'(r_report_interval));
    assign w_in_range     = (r_c_avg != '0) && (r_c_avg < r_threshold);
    assign w_detect       = r_c_ok && w_in_range && !r_flag;
    assign w_clear        = r_flag && (r_c_ok ? !w_in_range : w_timeout);
    assign w_flag_ev      = w_detect || w_clear;

    always_comb begin
        w_update_ev.kind  = odm_pkg::KIND_UPDATE;
        w_update_ev.value = r_c_avg;
        w_update_ev.last  = !w_flag_ev;

        w_flag_word.kind  = w_detect ? odm_pkg::KIND_DETECTED : odm_pkg::KIND_CLEARED;
        w_flag_word.value = r_c_ok ? r_c_avg : '0;
        w_flag_word.last  = 1'b1;

        w_push.count = '0;
        w_push.ev0   = w_report ? w_update_ev : w_flag_word;
        w_push.ev1   = w_flag_word;
        if (r_c_valid) begin
            w_push.count = 2'(w_report) + 2'(w_flag_ev);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag        <= 1'b0;
            r_last_valid  <= '0;
            r_last_report <= '0;
        end else if (r_c_valid) begin
            if (w_flag_ev) begin
                r_flag <= w_detect;
            end
            if (r_c_ok) begin
                r_last_valid <= r_c_now;
            end
            if (w_report) begin
                r_last_report <= r_c_now;
            end
        end
    end

    // Output buffer
    odm_pkg::t_event w_head;

    odm_event_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_ready),
        .o_head  (w_head),
        .o_valid (o_valid),
        .o_count (w_fifo_count)
    );

    assign o_event_kind  = w_head.kind;
    assign o_event_value = w_head.value;
    assign o_last_event  = w_head.last;

    // Checks
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_count <= odm_pkg::FIFO_CNT_W'(odm_pkg::FIFO_DEPTH))
        else $error("event buffer holds more words than its depth");

    a_accept_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> ##1 r_c_valid)
        else $error("accepted reading did not reach the decision stage");

    a_flag_has_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_flag) || $fell(r_flag)) |-> $past(w_push.count != 2'd0))
        else $error("obstacle flag changed without an event word");

    a_room_for_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.count == 2'd2) |->
            (odm_pkg::CREDIT_W'(w_fifo_count) + odm_pkg::CREDIT_W'(2)
                <= odm_pkg::CREDIT_W'(odm_pkg::FIFO_DEPTH)))
        else $error("event push would overflow the buffer");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for obstacle_distance_monitor_top: readings in, events out, APB setup.
// Depends on odm_pkg and the RTL under hdl/; holds its own copy of the window and flag logic.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import odm_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic [TIME_W-1:0]   now;
    } reading_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [SAMPLE_W-1:0] i_raw_distance = '0;
    logic [TIME_W-1:0]   i_now_ms = '0;
    logic                o_valid;
    logic                i_ready = 1'b1;
    logic [1:0]          o_event_kind;
    logic [SAMPLE_W-1:0] o_event_value;
    logic                o_last_event;

    obstacle_distance_monitor_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_raw_distance (i_raw_distance),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_kind   (o_event_kind),
        .o_event_value  (o_event_value),
        .o_last_event   (o_last_event)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Settings as the block holds them
    logic [SAMPLE_W-1:0] limit_cfg    = RST_VALID_LIMIT;
    logic [SAMPLE_W-1:0] thresh_cfg   = RST_OBST_THRESHOLD;
    logic [MS_W-1:0]     timeout_cfg  = RST_LOSS_TIMEOUT;
    logic [MS_W-1:0]     interval_cfg = RST_REPORT_INTERVAL;

    // Window and flag state
    logic [SAMPLE_W-1:0] window_mem [WINDOW] = '{default: '0};
    int                  slot = 0;
    logic                obstacle_flag = 1'b0;
    logic [TIME_W-1:0]   last_valid_ms = '0;
    logic [TIME_W-1:0]   last_report_ms = '0;

    reading_t        reading_q [$];
    t_event          pending_events [$];
    reading_t        next_reading;
    logic [TIME_W-1:0] stamp_ms = '0;
    int              mismatch_count = 0;
    bit              reading_taken = 1'b0;
    int              send_gap = 0;
    int              gap_max = 7;
    int              hold_left = 0;
    int              stall_max = 7;

    function automatic t_event make_event(logic [1:0] kind, logic [SAMPLE_W-1:0] value);
        t_event ev;
        ev.kind  = kind;
        ev.value = value;
        ev.last  = 1'b0;
        return ev;
    endfunction

    task automatic predict_events(input logic [SAMPLE_W-1:0] raw, input logic [TIME_W-1:0] now);
        t_event            evs [2];
        int                n;
        int unsigned       sum;
        logic [SAMPLE_W-1:0] avg;
        logic [TIME_W-1:0] elapsed;
        n = 0;
        sum = 0;
        if (raw == '0 || raw >= limit_cfg) begin
            elapsed = now - last_valid_ms;
            if (elapsed > TIME_W'(timeout_cfg) && obstacle_flag) begin
                obstacle_flag = 1'b0;
                evs[n] = make_event(KIND_CLEARED, '0);
                n++;
            end
        end else begin
            last_valid_ms = now;
            window_mem[slot] = raw;
            slot = (slot + 1) % WINDOW;
            foreach (window_mem[i]) sum += window_mem[i];
            avg = SAMPLE_W'(sum / WINDOW);
            elapsed = now - last_report_ms;
            if (elapsed > TIME_W'(interval_cfg)) begin
                last_report_ms = now;
                evs[n] = make_event(KIND_UPDATE, avg);
                n++;
            end
            if (avg != '0 && avg < thresh_cfg) begin
                if (!obstacle_flag) begin
                    obstacle_flag = 1'b1;
                    evs[n] = make_event(KIND_DETECTED, avg);
                    n++;
                end
            end else if (obstacle_flag) begin
                obstacle_flag = 1'b0;
                evs[n] = make_event(KIND_CLEARED, avg);
                n++;
            end
        end
        if (n > 0) evs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) pending_events.push_back(evs[k]);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Sample handshakes on the rising edge
    always @(posedge i_clk) begin
        t_event got;
        t_event want;
        reading_taken = 1'b0;
        if (i_rst_n) begin
            reading_taken = i_valid && o_ready;
            if (reading_taken) predict_events(i_raw_distance, i_now_ms);
            if (o_valid && i_ready) begin
                got.kind  = o_event_kind;
                got.value = o_event_value;
                got.last  = o_last_event;
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected word: kind %0d value %0d last %0d",
                                              got.kind, got.value, got.last));
                end else begin
                    want = pending_events.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.last !== want.last)
                        report_mismatch($sformatf(
                            "word differs: expected kind %0d value %0d last %0d, got %0d %0d %0d",
                            want.kind, want.value, want.last, got.kind, got.value, got.last));
                end
                hold_left = $urandom_range(0, stall_max);
            end
        end
    end

    // Reading driver: hold until taken, then idle for the drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !reading_taken) begin
            // hold the word
        end else if (send_gap > 0) begin
            i_valid <= 1'b0;
            send_gap--;
        end else if (reading_q.size() > 0) begin
            next_reading = reading_q.pop_front();
            i_raw_distance <= next_reading.raw;
            i_now_ms <= next_reading.now;
            i_valid <= 1'b1;
            send_gap = $urandom_range(0, gap_max);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Event receiver stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [1:0] reg_idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_VALID_LIMIT:     limit_cfg    = data[SAMPLE_W-1:0];
            REG_OBST_THRESHOLD:  thresh_cfg   = data[SAMPLE_W-1:0];
            REG_LOSS_TIMEOUT:    timeout_cfg  = data[MS_W-1:0];
            REG_REPORT_INTERVAL: interval_cfg = data[MS_W-1:0];
            default: ;
        endcase
    endtask

    // Write all four registers; upper bits of each word carry junk
    task automatic apply_settings(input logic [SAMPLE_W-1:0] limit, input logic [SAMPLE_W-1:0] thr,
                                  input logic [MS_W-1:0] timeout, input logic [MS_W-1:0] interval);
        logic [DATA_W-1:0] junk;
        junk = $urandom;
        apb_write(REG_VALID_LIMIT, {junk[DATA_W-1:SAMPLE_W], limit});
        junk = $urandom;
        apb_write(REG_OBST_THRESHOLD, {junk[DATA_W-1:SAMPLE_W], thr});
        junk = $urandom;
        apb_write(REG_LOSS_TIMEOUT, {junk[DATA_W-1:MS_W], timeout});
        junk = $urandom;
        apb_write(REG_REPORT_INTERVAL, {junk[DATA_W-1:MS_W], interval});
    endtask

    task automatic push_reading(input logic [SAMPLE_W-1:0] raw, input logic [TIME_W-1:0] now);
        reading_t r;
        r.raw = raw;
        r.now = now;
        reading_q.push_back(r);
    endtask

    // Runs of near, far, invalid or random readings so the flag toggles and timeouts expire
    task automatic queue_readings(input int count);
        int          left_in_run;
        int          pattern;
        int          valid_top;
        int          near_top;
        int          far_low;
        int          sel;
        logic [SAMPLE_W-1:0] raw;
        logic [TIME_W-1:0]   delta;
        left_in_run = 0;
        pattern = 0;
        repeat (count) begin
            if (left_in_run == 0) begin
                pattern = $urandom_range(0, 9);
                left_in_run = $urandom_range(3, 9);
            end
            left_in_run--;
            valid_top = (limit_cfg > 1) ? limit_cfg - 1 : 1;
            near_top  = (thresh_cfg > 1) ? thresh_cfg : 1;
            if (near_top > valid_top) near_top = valid_top;
            far_low   = (thresh_cfg < valid_top) ? thresh_cfg : valid_top;
            if (pattern <= 3)
                raw = SAMPLE_W'($urandom_range(1, near_top));
            else if (pattern <= 6)
                raw = SAMPLE_W'($urandom_range(far_low, valid_top));
            else if (pattern <= 8)
                raw = $urandom_range(0, 1) ? '0 : SAMPLE_W'($urandom_range(limit_cfg, SAMPLE_MAX));
            else
                raw = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            sel = $urandom_range(0, 19);
            if (pattern >= 7 && sel < 12)
                delta = $urandom_range(0, 2 * timeout_cfg + 20);
            else if (sel < 12)
                delta = $urandom_range(0, 2 * interval_cfg + 20);
            else if (sel < 17)
                delta = $urandom_range(0, timeout_cfg + timeout_cfg / 2 + 20);
            else if (sel < 19)
                delta = $urandom_range(0, 200000);
            else
                delta = $urandom;
            stamp_ms = stamp_ms + delta;
            push_reading(raw, stamp_ms);
        end
    endtask

    // Wait for the last word, then let the pipeline settle
    task automatic wait_drained();
        while (reading_q.size() != 0 || i_valid || pending_events.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: limit edges, interval edge, detect, timeout clear, two-word item, wrap
        push_reading(10'd0,    32'd0);
        push_reading(10'd1023, 32'd10);
        push_reading(10'd400,  32'd20);
        push_reading(10'd399,  32'd51);
        push_reading(10'd1,    32'd101);
        push_reading(10'd1,    32'd152);
        push_reading(10'd1,    32'd160);
        push_reading(10'd1,    32'd170);
        push_reading(10'd1,    32'd180);
        push_reading(10'd1,    32'd190);
        push_reading(10'd1,    32'd300);
        push_reading(10'd0,    32'd800);
        push_reading(10'd0,    32'd801);
        push_reading(10'd2,    32'd900);
        push_reading(10'd399,  32'd1000);
        push_reading(10'd10,   32'hFFFF_FFF0);
        push_reading(10'd10,   32'h0000_0010);
        push_reading(10'd10,   32'h0000_0030);
        push_reading(10'd5,    32'hFFFF_FFFF);
        push_reading(10'd512,  32'h0000_0040);
        wait_drained();

        apply_settings(10'd1023, 10'd1023, 16'd0, 16'd0);
        queue_readings(30);
        wait_drained();

        // Zero limit: nothing is valid, only timeout clears
        apply_settings(10'd0, 10'd25, 16'd10, 16'd5);
        queue_readings(15);
        wait_drained();

        apply_settings(10'd1, 10'd0, 16'hFFFF, 16'hFFFF);
        queue_readings(15);
        wait_drained();

        // Zero threshold: flag never sets
        apply_settings(10'd500, 10'd0, 16'd300, 16'd0);
        queue_readings(20);
        wait_drained();

        stamp_ms = $urandom;
        for (int phase = 0; phase < 8; phase++) begin
            gap_max   = (phase % 3 == 1) ? 0 : 7;
            stall_max = (phase % 3 == 1) ? 0 : 7;
            apply_settings(
                ($urandom_range(0, 3) == 0) ? 10'($urandom_range(1, 1023))
                                            : 10'($urandom_range(100, 600)),
                ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                            : 10'($urandom_range(10, 150)),
                ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 800)),
                ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 200)));
            queue_readings(50);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("obstacle_distance_monitor_top: match");
        end else begin
            $display("obstacle_distance_monitor_top: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("obstacle_distance_monitor_top: mismatch");
        $finish;
    end

endmodule
